@@ sv/mras_pkg.sv @@
`timescale 1ns / 1ps

package mras_pkg;

    localparam int VAR_W       = 10;
    localparam int WEIGHT_W    = 16;
    localparam int OBJ_W       = 32;
    localparam int COUNT_W     = 11;
    localparam int IDX_SPAN    = 2 ** VAR_W;
    localparam int MAX_VARS_DEF = 1024;

    localparam logic [OBJ_W-1:0]   OBJ_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Each table entry carries the epoch in which it was written; a mismatch
    // with the current epoch means the variable is unassigned.
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_STALE = '0;

    typedef enum logic [0:0] {
        CMD_LITERAL = 1'b0,
        CMD_CLEAR   = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                command;
        logic [VAR_W-1:0]    var_index;
        logic                negated;
        logic                last_in_clause;
        logic [WEIGHT_W-1:0] clause_weight;
        logic                random_bit;
    } t_in_item;

    typedef struct packed {
        logic               literal_true;
        logic               newly_assigned;
        logic               assigned_value;
        logic               clause_satisfied;
        logic [OBJ_W-1:0]   objective_total;
        logic [COUNT_W-1:0] variable_count;
    } t_out_item;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic               value;
    } t_entry;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic               busy;
    } t_epoch_status;

endpackage

@@ sv/mras_if.sv @@
`timescale 1ns / 1ps

interface mras_in_if import mras_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface mras_out_if import mras_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

@@ sv/mras_table.sv @@
`timescale 1ns / 1ps

module mras_table import mras_pkg::*; #(
    parameter int DEPTH = MAX_VARS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/mras_epoch.sv @@
`timescale 1ns / 1ps

module mras_epoch import mras_pkg::*; #(
    parameter int DEPTH = MAX_VARS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    output t_epoch_status o_status,
    output logic          o_sweep_we,
    output logic [AW-1:0] o_sweep_addr
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [EPOCH_W-1:0] r_epoch;
    logic               r_busy;
    logic [AW-1:0]      r_addr;

    // When the epoch counter runs out, every tag is rewritten to the stale
    // value so that old entries can never alias a reused epoch.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= EPOCH_FIRST;
            r_busy  <= 1'b1;
            r_addr  <= '0;
        end else if (r_busy) begin
            r_addr <= r_addr + AW'(1);
            if (r_addr == LAST_ADDR) begin
                r_busy <= 1'b0;
            end
        end else if (i_clear) begin
            if (r_epoch == EPOCH_MAX) begin
                r_epoch <= EPOCH_FIRST;
                r_busy  <= 1'b1;
                r_addr  <= '0;
            end else begin
                r_epoch <= r_epoch + EPOCH_W'(1);
            end
        end
    end

    assign o_status.epoch = r_epoch;
    assign o_status.busy  = r_busy;
    assign o_sweep_we     = r_busy;
    assign o_sweep_addr   = r_addr;

endmodule

@@ sv/maxsat_random_assign_scorer.sv @@
`timescale 1ns / 1ps
// An accepted beat is registered with its table read, then evaluated and
// registered as its result beat. Throughput: one beat per cycle while the
// result side is ready; the table read-modify-write and the 32-bit saturating
// add both sit in the single evaluate stage after the table read. Every 255th
// clear command starts a sweep of all MAX_VARS table entries (at most 1024)
// during which no beat is accepted; a synchronous reset also starts one.
module maxsat_random_assign_scorer import mras_pkg::*; #(
    parameter int MAX_VARS = MAX_VARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mras_in_if.sink    i_in,
    mras_out_if.source o_out
);

    localparam int DEPTH = (MAX_VARS < IDX_SPAN) ? MAX_VARS : IDX_SPAN;
    localparam int AW    = $clog2(DEPTH);

    t_epoch_status epoch_st;
    logic          sweep_we;
    logic [AW-1:0] sweep_addr;

    logic          tbl_wr_en;
    logic [AW-1:0] tbl_wr_addr;
    t_entry        tbl_wr_data;
    t_entry        tbl_rd_data;

    logic          in_fire;
    logic [AW-1:0] in_addr;

    logic          r_s1_valid;
    t_in_item      r_s1_item;
    logic          r_s1_hit;
    t_entry        r_s1_fwd;

    logic               r_clause_done;
    logic [OBJ_W-1:0]   r_obj;
    logic [COUNT_W-1:0] r_count;

    logic      r_out_valid;
    t_out_item r_out;

    logic               s1_fire;
    logic               s1_clear;
    logic               s1_wr;
    logic [AW-1:0]      s1_addr;
    t_entry             cur;
    logic               in_range;
    logic               mark;
    logic [OBJ_W:0]     sum;
    logic               n_clause_done;
    logic [OBJ_W-1:0]   n_obj;
    logic [COUNT_W-1:0] n_count;
    t_out_item          n_out;

    assign s1_fire  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign s1_clear = r_s1_item.command == CMD_CLEAR;

    // A clear that exhausts the epochs starts a sweep; hold the input then.
    assign i_in.ready = !epoch_st.busy &&
                        (!r_s1_valid ||
                         (s1_fire && !(s1_clear && epoch_st.epoch == EPOCH_MAX)));
    assign in_fire    = i_in.valid && i_in.ready;
    assign in_addr    = i_in.data.var_index[AW-1:0];
    assign s1_addr    = r_s1_item.var_index[AW-1:0];

    mras_epoch #(.DEPTH(DEPTH), .AW(AW)) u_epoch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (s1_fire && s1_clear),
        .o_status     (epoch_st),
        .o_sweep_we   (sweep_we),
        .o_sweep_addr (sweep_addr)
    );

    mras_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (in_fire),
        .i_rd_addr (in_addr),
        .o_rd_data (tbl_rd_data),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data)
    );

    // Evaluate stage.
    always_comb begin
        cur      = r_s1_hit ? r_s1_fwd : tbl_rd_data;
        in_range = 32'(r_s1_item.var_index) < 32'(MAX_VARS);
        mark     = cur.tag == epoch_st.epoch;
        sum      = {1'b0, r_obj} + (OBJ_W + 1)'(r_s1_item.clause_weight);

        n_clause_done = r_clause_done;
        n_obj         = r_obj;
        n_count       = r_count;
        s1_wr         = 1'b0;
        n_out         = '0;

        if (s1_clear) begin
            n_clause_done = 1'b0;
            n_obj         = '0;
            n_count       = '0;
        end else begin
            if (r_clause_done) begin
                n_out.clause_satisfied = 1'b1;
            end else if (in_range) begin
                if (!mark) begin
                    s1_wr                = 1'b1;
                    n_out.newly_assigned = 1'b1;
                    n_out.assigned_value = r_s1_item.random_bit;
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + COUNT_W'(1);
                    end
                end else begin
                    n_out.assigned_value = cur.value;
                end
                n_out.literal_true = n_out.assigned_value ^ r_s1_item.negated;
                if (n_out.literal_true) begin
                    n_out.clause_satisfied = 1'b1;
                    n_clause_done          = 1'b1;
                    n_obj = sum[OBJ_W] ? OBJ_MAX : sum[OBJ_W-1:0];
                end
            end
            if (r_s1_item.last_in_clause) begin
                n_clause_done = 1'b0;
            end
        end
        n_out.objective_total = n_obj;
        n_out.variable_count  = n_count;
    end

    always_comb begin
        if (sweep_we) begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = sweep_addr;
            tbl_wr_data = '{tag: EPOCH_STALE, value: 1'b0};
        end else begin
            tbl_wr_en   = s1_fire && s1_wr;
            tbl_wr_addr = s1_addr;
            tbl_wr_data = '{tag: epoch_st.epoch, value: r_s1_item.random_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_clause_done <= 1'b0;
            r_obj         <= '0;
            r_count       <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid   <= 1'b1;
                r_clause_done <= n_clause_done;
                r_obj         <= n_obj;
                r_count       <= n_count;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The table read of a beat accepted in the same cycle as a write to the
    // same entry returns the old contents, so the written entry is forwarded.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= i_in.data;
            r_s1_hit  <= s1_fire && s1_wr && (s1_addr == in_addr);
            r_s1_fwd  <= '{tag: epoch_st.epoch, value: r_s1_item.random_bit};
        end
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

@@ tb/sv/mras_score_checker.sv @@
`timescale 1ns / 1ps

module mras_score_checker import mras_pkg::*; #(
    parameter int MAX_VARS = MAX_VARS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mras_in_if   in_mon,
    mras_out_if  out_mon,
    output int   o_mismatch_count,
    output int   o_pending
);

    // Shadow copy of the assignment table and the running totals.
    bit               var_seen  [MAX_VARS];
    bit               var_value [MAX_VARS];
    bit               clause_met;
    logic [OBJ_W-1:0]   objective;
    logic [COUNT_W-1:0] assigned_vars;

    t_out_item expected_scores[$];

    // Applies one input beat to the shadow state and returns the result it must produce.
    function automatic t_out_item score_literal(input t_in_item beat);
        t_out_item res;
        res = '0;
        if (beat.command == CMD_CLEAR) begin
            foreach (var_seen[i]) var_seen[i] = 1'b0;
            clause_met    = 1'b0;
            objective     = '0;
            assigned_vars = '0;
        end else begin
            if (clause_met) begin
                // The clause already holds, so this literal is passed over untouched.
                res.clause_satisfied = 1'b1;
            end else if (int'(beat.var_index) < MAX_VARS) begin
                if (!var_seen[beat.var_index]) begin
                    var_seen[beat.var_index]  = 1'b1;
                    var_value[beat.var_index] = beat.random_bit;
                    res.newly_assigned        = 1'b1;
                    if (assigned_vars != COUNT_MAX) assigned_vars++;
                end
                res.assigned_value = var_value[beat.var_index];
                res.literal_true   = var_value[beat.var_index] ^ beat.negated;
                if (res.literal_true) begin
                    res.clause_satisfied = 1'b1;
                    clause_met           = 1'b1;
                    if (objective > OBJ_MAX - OBJ_W'(beat.clause_weight)) begin
                        objective = OBJ_MAX;
                    end else begin
                        objective = objective + OBJ_W'(beat.clause_weight);
                    end
                end
            end
            if (beat.last_in_clause) clause_met = 1'b0;
        end
        res.objective_total = objective;
        res.variable_count  = assigned_vars;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR: %s", $realtime, msg);
        o_mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [OBJ_W-1:0] got,
                               input logic [OBJ_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin : monitor
        t_in_item  wipe;
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            wipe         = '0;
            wipe.command = CMD_CLEAR;
            void'(score_literal(wipe));
            expected_scores.delete();
        end else begin
            if (in_mon.valid && in_mon.ready)
                expected_scores.insert(expected_scores.size(), score_literal(in_mon.data));
            if (out_mon.valid && out_mon.ready) begin
                got = out_mon.data;
                if (expected_scores.size() == 0) begin
                    report_mismatch($sformatf("result beat %h with nothing pending", got));
                end else begin
                    want = expected_scores.pop_front();
                    check_field("literal_true", OBJ_W'(got.literal_true),
                                OBJ_W'(want.literal_true));
                    check_field("newly_assigned", OBJ_W'(got.newly_assigned),
                                OBJ_W'(want.newly_assigned));
                    check_field("assigned_value", OBJ_W'(got.assigned_value),
                                OBJ_W'(want.assigned_value));
                    check_field("clause_satisfied", OBJ_W'(got.clause_satisfied),
                                OBJ_W'(want.clause_satisfied));
                    check_field("objective_total", got.objective_total,
                                want.objective_total);
                    check_field("variable_count", OBJ_W'(got.variable_count),
                                OBJ_W'(want.variable_count));
                end
            end
        end
        o_pending = expected_scores.size();
    end

endmodule

@@ tb/sv/tb_maxsat_random_assign_scorer.sv @@
`timescale 1ns / 1ps

module tb_maxsat_random_assign_scorer;
    import mras_pkg::*;

    localparam int TB_MAX_VARS   = MAX_VARS_DEF;
    localparam int RANDOM_CHUNK  = 150;
    localparam int SAT_CLAUSES   = 120;
    localparam int EPOCH_ROUNDS  = 260;
    localparam int IN_W          = $bits(t_in_item);

    logic i_clk;
    logic i_rst_n;

    int mismatch_count;
    int pending_count;
    int send_idle_pct;
    int recv_stall_pct;
    int recv_hold_len;
    bit run_value [TB_MAX_VARS];

    mras_in_if  in_ch();
    mras_out_if out_ch();

    maxsat_random_assign_scorer #(
        .MAX_VARS(TB_MAX_VARS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    mras_score_checker #(
        .MAX_VARS(TB_MAX_VARS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .in_mon          (in_ch),
        .out_mon         (out_ch),
        .o_mismatch_count(mismatch_count),
        .o_pending       (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_hold_len > 0) begin
                out_ch.ready <= 1'b0;
                repeat (recv_hold_len) @(negedge i_clk);
                recv_hold_len = 0;
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_in_item make_literal(input int idx, input bit neg, input bit last,
                                              input int weight, input bit rbit);
        t_in_item beat;
        beat.command        = CMD_LITERAL;
        beat.var_index      = VAR_W'(idx);
        beat.negated        = neg;
        beat.last_in_clause = last;
        beat.clause_weight  = WEIGHT_W'(weight);
        beat.random_bit     = rbit;
        return beat;
    endfunction

    // The other fields of a clear beat carry junk that the block has to ignore.
    function automatic t_in_item make_clear();
        t_in_item beat;
        beat         = IN_W'($urandom);
        beat.command = CMD_CLEAR;
        return beat;
    endfunction

    function automatic t_in_item random_beat();
        t_in_item beat;
        beat         = IN_W'($urandom);
        beat.command = ($urandom_range(19) == 0) ? CMD_CLEAR : CMD_LITERAL;
        return beat;
    endfunction

    // Called at a falling edge; returns at a falling edge after the beat is taken.
    task automatic send_beat(input t_in_item beat);
        in_ch.valid <= 1'b1;
        in_ch.data  <= beat;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= IN_W'($urandom);
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Mostly whole clauses over a mix of a small hot pool and the full index range,
    // with the odd clear and some fully random beats mixed in.
    task automatic run_random(input int count);
        int sent;
        int pick;
        int len;
        int weight;
        int idx;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                send_beat(make_clear());
                sent++;
            end else if (pick < 18) begin
                send_beat(random_beat());
                sent++;
            end else begin
                len = $urandom_range(4, 1);
                case ($urandom_range(3))
                    0:       weight = 0;
                    1:       weight = 'hFFFF;
                    default: weight = $urandom_range('hFFFF);
                endcase
                for (int k = 0; k < len; k++) begin
                    idx = $urandom_range(1) ? $urandom_range(15) : $urandom_range(IDX_SPAN - 1);
                    send_beat(make_literal(idx, 1'($urandom_range(1)), k == len - 1, weight,
                                           1'($urandom_range(1))));
                end
                sent += len;
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        recv_hold_len = 0;
        set_idling(0, 0);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: satisfied and skipped literals, unsatisfied clauses,
        // table extremes, zero and full weights, and clears with junk fields.
        send_beat(make_clear());
        send_beat(make_literal(0, 1'b0, 1'b0, 'hFFFF, 1'b1));
        send_beat(make_literal(7, 1'b0, 1'b1, 'hFFFF, 1'b1));
        send_beat(make_literal(1023, 1'b0, 1'b0, 1, 1'b0));
        send_beat(make_literal(1023, 1'b1, 1'b1, 1, 1'b1));
        send_beat(make_literal(0, 1'b1, 1'b1, 5, 1'b0));
        send_beat(make_literal(512, 1'b1, 1'b0, 0, 1'b1));
        send_beat(make_literal(341, 1'b1, 1'b1, 0, 1'b0));
        send_beat(make_literal(682, 1'b0, 1'b0, 'h8000, 1'b1));
        send_beat(make_literal(682, 1'b0, 1'b0, 'h7FFF, 1'b0));
        send_beat(make_literal(5, 1'b1, 1'b1, 'hFFFF, 1'b1));
        send_beat(make_clear());
        send_beat(make_literal(0, 1'b0, 1'b1, 3, 1'b0));
        send_beat(make_literal(0, 1'b1, 1'b1, 3, 1'b1));
        send_beat(make_clear());
        send_beat(make_clear());
        send_beat(make_literal(1023, 1'b1, 1'b1, 'hFFFF, 1'b1));
        send_beat(make_literal(1023, 1'b0, 1'b1, 'hFFFF, 1'b0));
        drain_results();

        // Hold the result side off long enough for the block to back up its input.
        recv_hold_len = 300;
        repeat (60) send_beat(random_beat());
        drain_results();

        run_random(RANDOM_CHUNK);

        // Every clause is true at full weight, so the objective climbs in large
        // steps; the closing literals on already assigned variables come out false.
        send_beat(make_clear());
        for (int k = 0; k < SAT_CLAUSES; k++) begin
            run_value[k] = 1'($urandom_range(1));
            send_beat(make_literal(k, !run_value[k], 1'b1, 'hFFFF, run_value[k]));
        end
        for (int k = 0; k < 8; k++)
            send_beat(make_literal(k, run_value[k], 1'b1, 'hFFFF, 1'($urandom_range(1))));
        drain_results();

        set_idling(77, 0);
        run_random(RANDOM_CHUNK);
        drain_results();

        set_idling(0, 77);
        run_random(RANDOM_CHUNK);
        drain_results();

        // Enough clears to wrap the table generation at least once; each round
        // revisits a hot variable that must come back unassigned.
        set_idling(35, 35);
        for (int k = 0; k < EPOCH_ROUNDS; k++) begin
            send_beat(make_clear());
            send_beat(make_literal(k % 4, 1'($urandom_range(1)), 1'b1,
                                   $urandom_range('hFFFF), 1'($urandom_range(1))));
        end
        run_random(RANDOM_CHUNK);
        drain_results();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
